[rtl/sslt_pkg.sv]
// Shared types, request and status codes for the score sorted list table.
package sslt_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int IN_W  = 112;
    localparam int OUT_W = 112;

    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_GET     = 3'd1;
    localparam logic [2:0] REQ_DEL_IDX = 3'd2;
    localparam logic [2:0] REQ_FIND    = 3'd3;
    localparam logic [2:0] REQ_DEL_KEY = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_CHK,
        S_ADD_CMP,
        S_RD_IDX,
        S_TAKE,
        S_FIND_CHK,
        S_FIND_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_TOP,
        PTR_ZERO,
        PTR_IDX,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_BELOW,
        RD_AT,
        RD_ABOVE
    } rd_op_t;

    typedef struct packed {
        logic       load_req;
        ptr_op_t    ptr_op;
        rd_op_t     rd_op;
        logic       wr_move;
        logic       wr_new;
        logic       cnt_dec;
        logic       res_take;
        logic       res_clr;
        logic [1:0] res_code;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       full;
        logic       idx_oor;
        logic       ptr_zero;
        logic       ptr_at_end;
        logic       shift_last;
        logic       add_less;
        logic       key_hit;
        logic       out_free;
    } sts_t;

endpackage

[rtl/sslt_ram.sv]
// Generic single write port, single read port RAM with registered read.
module sslt_ram
#(
    parameter int WIDTH  = 96,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sslt_ctrl.sv]
// Request sequencer: walks the slot memory one step at a time per request.
module sslt_ctrl
    import sslt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.req)
                    REQ_ADD:
                    begin
                        state_next = sts.full ? S_DONE : S_ADD_CHK;
                    end
                    REQ_GET, REQ_DEL_IDX:
                    begin
                        state_next = sts.idx_oor ? S_DONE : S_RD_IDX;
                    end
                    REQ_FIND, REQ_DEL_KEY:
                    begin
                        state_next = S_FIND_CHK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ADD_CHK:
            begin
                state_next = sts.ptr_zero ? S_DONE : S_ADD_CMP;
            end
            S_ADD_CMP:
            begin
                state_next = sts.add_less ? S_ADD_CHK : S_DONE;
            end
            S_RD_IDX:
            begin
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                state_next = (sts.req == REQ_DEL_IDX) ? S_SHIFT_CHK : S_DONE;
            end
            S_FIND_CHK:
            begin
                state_next = sts.ptr_at_end ? S_DONE : S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (sts.key_hit)
                begin
                    state_next = (sts.req == REQ_DEL_KEY) ? S_SHIFT_CHK : S_DONE;
                end
                else
                begin
                    state_next = S_FIND_CHK;
                end
            end
            S_SHIFT_CHK:
            begin
                state_next = sts.shift_last ? S_DONE : S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_CHK;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.load_req = 1'b0;
        cmd.ptr_op   = PTR_HOLD;
        cmd.rd_op    = RD_NONE;
        cmd.wr_move  = 1'b0;
        cmd.wr_new   = 1'b0;
        cmd.cnt_dec  = 1'b0;
        cmd.res_take = 1'b0;
        cmd.res_clr  = 1'b0;
        cmd.res_code = ST_OK;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            S_DISPATCH:
            begin
                case (sts.req)
                    REQ_ADD:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_clr  = 1'b1;
                            cmd.res_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_TOP;
                        end
                    end
                    REQ_GET, REQ_DEL_IDX:
                    begin
                        if (sts.idx_oor)
                        begin
                            cmd.res_clr  = 1'b1;
                            cmd.res_code = ST_RANGE;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_IDX;
                        end
                    end
                    REQ_FIND, REQ_DEL_KEY:
                    begin
                        cmd.ptr_op = PTR_ZERO;
                    end
                    default:
                    begin
                        cmd.res_clr  = 1'b1;
                        cmd.res_code = ST_OK;
                    end
                endcase
            end
            S_ADD_CHK:
            begin
                if (sts.ptr_zero)
                begin
                    cmd.wr_new = 1'b1;
                end
                else
                begin
                    cmd.rd_op = RD_BELOW;
                end
            end
            S_ADD_CMP:
            begin
                // move the lower-scored neighbor up one slot, or drop the new item here
                if (sts.add_less)
                begin
                    cmd.wr_move = 1'b1;
                    cmd.ptr_op  = PTR_DEC;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                end
            end
            S_RD_IDX:
            begin
                cmd.rd_op = RD_AT;
            end
            S_TAKE:
            begin
                cmd.res_take = 1'b1;
            end
            S_FIND_CHK:
            begin
                if (sts.ptr_at_end)
                begin
                    cmd.res_clr  = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                end
                else
                begin
                    cmd.rd_op = RD_AT;
                end
            end
            S_FIND_CMP:
            begin
                if (sts.key_hit)
                begin
                    cmd.res_take = 1'b1;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            S_SHIFT_CHK:
            begin
                if (sts.shift_last)
                begin
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_op = RD_ABOVE;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_move = 1'b1;
                cmd.ptr_op  = PTR_INC;
            end
            S_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/sslt_dp.sv]
// Datapath: request registers, slot pointer, entry count, slot memory and result register.
module sslt_dp
    import sslt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  cmd_t             cmd,
    output sts_t             sts
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 96;

    logic [2:0]    req_reg;
    logic [5:0]    idx_reg;
    logic [31:0]   score_reg;
    logic [63:0]   key_reg;

    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic [1:0]    res_status_reg;
    logic [CW-1:0] res_pos_reg;
    logic [31:0]   res_score_reg;
    logic [63:0]   res_key_reg;

    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic [CW-1:0] ptr_m1;
    logic [CW:0]   ptr_p1;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    assign ptr_m1 = ptr_reg - CW'(1);
    assign ptr_p1 = {1'b0, ptr_reg} + (CW + 1)'(1);

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = ptr_reg[AW-1:0];
        case (cmd.rd_op)
            RD_BELOW: rd_addr = ptr_m1[AW-1:0];
            RD_AT:    rd_addr = ptr_reg[AW-1:0];
            RD_ABOVE: rd_addr = ptr_p1[AW-1:0];
            default:  rd_en   = 1'b0;
        endcase
    end

    assign wr_en   = cmd.wr_move | cmd.wr_new;
    assign wr_addr = ptr_reg[AW-1:0];
    assign wr_data = cmd.wr_new ? {key_reg, score_reg} : rd_data;

    sslt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // request fields
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg   <= s_tdata[2:0];
            idx_reg   <= s_tdata[8:3];
            score_reg <= s_tdata[40:9];
            key_reg   <= s_tdata[104:41];
        end
    end

    always_comb
    begin
        case (cmd.ptr_op)
            PTR_TOP:  ptr_next = cnt_reg;
            PTR_ZERO: ptr_next = '0;
            PTR_IDX:  ptr_next = CW'(idx_reg);
            PTR_INC:  ptr_next = ptr_p1[CW-1:0];
            PTR_DEC:  ptr_next = ptr_m1;
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.wr_new)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg      <= ptr_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result of the request in progress
    always_ff @(posedge clk)
    begin
        if (cmd.wr_new)
        begin
            res_status_reg <= ST_OK;
            res_pos_reg    <= ptr_reg;
            res_score_reg  <= score_reg;
            res_key_reg    <= key_reg;
        end
        else if (cmd.res_take)
        begin
            res_status_reg <= ST_OK;
            res_pos_reg    <= ptr_reg;
            res_score_reg  <= rd_data[31:0];
            res_key_reg    <= rd_data[95:32];
        end
        else if (cmd.res_clr)
        begin
            res_status_reg <= cmd.res_code;
            res_pos_reg    <= '0;
            res_score_reg  <= '0;
            res_key_reg    <= '0;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {1'b0, 7'(cnt_reg), res_key_reg, res_score_reg,
                            6'(res_pos_reg), res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign sts.req        = req_reg;
    assign sts.full       = (cnt_reg == CW'(CAPACITY));
    assign sts.idx_oor    = (int'(idx_reg) >= int'(cnt_reg));
    assign sts.ptr_zero   = (ptr_reg == '0);
    assign sts.ptr_at_end = (ptr_reg >= cnt_reg);
    assign sts.shift_last = (ptr_p1 >= {1'b0, cnt_reg});
    assign sts.add_less   = ($signed(rd_data[31:0]) < $signed(score_reg));
    assign sts.key_hit    = (rd_data[95:32] == key_reg);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

endmodule

[rtl/score_sorted_list_table_unit.sv]
// Out-of-range, full and unused requests go straight to the result; get reads the indexed
// slot; add, find and the deletes walk the slots one step at a time. Each slot step is a
// registered RAM read, then compare or write back. Throughput: one item at a time; s_tready
// returns the cycle after the result is loaded into the output register, and a stalled
// m_tready holds that load off.
// Reset clears state, pointer, entry count and output valid; slot contents are not cleared.
module score_sorted_list_table_unit
    import sslt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // req_type[2:0], index[8:3], entry_score[40:9], entry_key[104:41], zero fill
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[1:0], found_index[7:2], score_out[39:8], key_out[103:40],
    // count_out[110:104], zero fill
    output logic [OUT_W-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    sslt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sslt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
